// ----- rtl/escape_key_decoder_cursor_core_assert.svh -----
// ----------------------------------------------------------------------------
// escape_key_decoder_cursor_core_assert.svh
// Assertion macros for the escape key decoder. They expect clk and rst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_KEY_DECODER_CURSOR_CORE_ASSERT_SVH
`define ESCAPE_KEY_DECODER_CURSOR_CORE_ASSERT_SVH

// same-cycle implication
`define EKD_ASSERT_HOLDS(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ekd: same-cycle check failed");

// next-cycle implication
`define EKD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ekd: next-cycle check failed");

`endif

// ----- rtl/ekd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekd_pkg
// Shared types and constants of the escape key decoder.
// ----------------------------------------------------------------------------
package ekd_pkg;

  localparam int KEY_W      = 9;
  localparam int POS_W      = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_DATA_W-1:0] SCREEN_ROWS_RST = 10'd24;
  localparam logic [CFG_DATA_W-1:0] SCREEN_COLS_RST = 10'd80;

  localparam logic [KEY_W-1:0] KEY_ESC   = 9'd27;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 9'd256;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 9'd257;
  localparam logic [KEY_W-1:0] KEY_UP    = 9'd258;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 9'd259;
  localparam logic [KEY_W-1:0] KEY_PGUP  = 9'd260;
  localparam logic [KEY_W-1:0] KEY_PGDN  = 9'd261;
  localparam logic [KEY_W-1:0] KEY_HOME  = 9'd262;
  localparam logic [KEY_W-1:0] KEY_END   = 9'd263;
  localparam logic [KEY_W-1:0] KEY_DEL   = 9'd264;

  localparam logic [7:0] CTRL_MASK = 8'h1F;
  // Ctrl-Q
  localparam logic [KEY_W-1:0] KEY_QUIT = {1'b0, 8'h71 & CTRL_MASK};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_ROWS,
    REG_SCREEN_COLS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_FOLLOW,
    PH_DIGIT
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic             key_valid;
    logic [KEY_W-1:0] key_code;
  } key_word_t;

  typedef struct packed {
    logic             key_valid;
    logic [KEY_W-1:0] key_code;
    logic [POS_W-1:0] cursor_col;
    logic [POS_W-1:0] cursor_row;
    logic             quit;
  } out_word_t;

endpackage

// ----- rtl/escape_key_decoder_cursor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_key_decoder_cursor_core
// Terminal escape sequence key decoder driving a clamped text cursor.
//
// Input side is a queue: write a word (cmd, in_byte) with push while full is
// low. Result side is a queue too: while empty is low, out_word holds the
// oldest result; pop takes it. Every input word yields exactly one result.
// The parser takes one word per cycle into a key queue while full is low;
// the cursor stage drains that queue at one key per cycle into the result
// queue while that is not full, so the block sustains one word per clock
// while the consumer keeps popping. A word passes the key queue, then the
// result queue, before out_word shows it. If the consumer stops popping,
// the result queue fills, then the key queue, then full rises; no word is
// dropped. Reset (synchronous, rst_n low) empties both queues, returns the
// parser to idle, puts the cursor at 0,0 and loads 24 rows by 80 columns.
// Screen size writes (cfg_we, cfg_idx, cfg_wdata) take effect at once and
// belong in idle periods.
// ----------------------------------------------------------------------------
module escape_key_decoder_cursor_core #(
  parameter int QUEUE_DEPTH = ekd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  ekd_pkg::in_word_t               in_word,
  output logic                            empty,
  input  logic                            pop,
  output ekd_pkg::out_word_t              out_word,
  input  logic                            cfg_we,
  input  logic [ekd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ekd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import ekd_pkg::*;

  key_word_t parse_word;
  key_word_t key_word;
  logic      key_empty;
  logic      key_pop;
  out_word_t res_word;
  logic      res_push;
  logic      res_full;
  logic      accept;

  assign accept = push && !full;

  ekd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_word),
    .key_word (parse_word)
  );

  ekd_fifo #(
    .WIDTH ($bits(key_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_key_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (parse_word),
    .full  (full),
    .pop   (key_pop),
    .dout  (key_word),
    .empty (key_empty)
  );

  ekd_cursor u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .key_word  (key_word),
    .key_empty (key_empty),
    .key_pop   (key_pop),
    .res_word  (res_word),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  ekd_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_word),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_word),
    .empty (empty)
  );

`include "escape_key_decoder_cursor_core_assert.svh"

  `EKD_ASSERT_HOLDS(a_nokey_zero, !empty && !out_word.key_valid, out_word.key_code == '0 && !out_word.quit)
  `EKD_ASSERT_HOLDS(a_quit_code, !empty && out_word.quit, out_word.key_valid && out_word.key_code == KEY_QUIT)
  `EKD_ASSERT_HOLDS(a_code_range, !empty && out_word.key_valid, out_word.key_code <= KEY_DEL)
  `EKD_ASSERT_NEXT(a_full_needs_push, !full && !push, !full)

endmodule

// ----- rtl/ekd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ekd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/ekd_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekd_parse
// Front end: escape sequence parser, one accepted word per cycle to key queue.
// ----------------------------------------------------------------------------
module ekd_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  ekd_pkg::in_word_t   in_word,
  output ekd_pkg::key_word_t  key_word
);

  import ekd_pkg::*;

  localparam logic [7:0] CHAR_ESC   = 8'h1B;
  localparam logic [7:0] CHAR_LBRKT = 8'h5B;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  function automatic logic [KEY_W-1:0] map_tilde(input logic [7:0] d);
    logic [KEY_W-1:0] k;
    unique case (d)
      8'h31, 8'h37: k = KEY_HOME;
      8'h33:        k = KEY_DEL;
      8'h34, 8'h38: k = KEY_END;
      8'h35:        k = KEY_PGUP;
      8'h36:        k = KEY_PGDN;
      default:      k = KEY_ESC;
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] map_letter(input logic [7:0] first,
                                                  input logic [7:0] b);
    logic [KEY_W-1:0] k;
    k = KEY_ESC;
    if (first == CHAR_LBRKT) begin
      unique case (b)
        8'h41:   k = KEY_UP;
        8'h42:   k = KEY_DOWN;
        8'h43:   k = KEY_RIGHT;
        8'h44:   k = KEY_LEFT;
        8'h48:   k = KEY_HOME;
        8'h46:   k = KEY_END;
        default: k = KEY_ESC;
      endcase
    end else if (first == CHAR_O) begin
      if (b == 8'h48) begin
        k = KEY_HOME;
      end else if (b == 8'h46) begin
        k = KEY_END;
      end
    end
    return k;
  endfunction

  phase_t     phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] digit_r, digit_nxt;
  logic [7:0] b;
  logic       is_digit_seq;

  assign b            = in_word.in_byte;
  assign is_digit_seq = (first_r == CHAR_LBRKT) && (b >= CHAR_ZERO) && (b <= CHAR_NINE);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    digit_nxt = digit_r;
    if (accept) begin
      if (in_word.cmd) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (b == CHAR_ESC) begin
              phase_nxt = PH_ESC;
            end
          end
          PH_ESC: begin
            first_nxt = b;
            phase_nxt = PH_FOLLOW;
          end
          PH_FOLLOW: begin
            if (is_digit_seq) begin
              digit_nxt = b;
              phase_nxt = PH_DIGIT;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_DIGIT: phase_nxt = PH_IDLE;
          default:  phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // decoded key
  always_comb begin
    key_word = '0;
    if (in_word.cmd) begin
      if (phase_r != PH_IDLE) begin
        key_word.key_valid = 1'b1;
        key_word.key_code  = KEY_ESC;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (b != CHAR_ESC) begin
            key_word.key_valid = 1'b1;
            key_word.key_code  = {1'b0, b};
          end
        end
        PH_ESC: key_word = '0;
        PH_FOLLOW: begin
          if (!is_digit_seq) begin
            key_word.key_valid = 1'b1;
            key_word.key_code  = map_letter(first_r, b);
          end
        end
        PH_DIGIT: begin
          key_word.key_valid = 1'b1;
          key_word.key_code  = (b == CHAR_TILDE) ? map_tilde(digit_r) : KEY_ESC;
        end
        default: key_word = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      first_r <= '0;
      digit_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

// ----- rtl/ekd_cursor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekd_cursor
// Back end: applies decoded keys to the clamped cursor, holds the screen
// size registers and builds the result word.
// ----------------------------------------------------------------------------
module ekd_cursor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ekd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ekd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  ekd_pkg::key_word_t              key_word,
  input  logic                            key_empty,
  output logic                            key_pop,
  output ekd_pkg::out_word_t              res_word,
  output logic                            res_push,
  input  logic                            res_full
);

  import ekd_pkg::*;

  logic [CFG_DATA_W-1:0] rows_r, rows_nxt;
  logic [CFG_DATA_W-1:0] cols_r, cols_nxt;
  logic [POS_W-1:0]      col_r, col_nxt;
  logic [POS_W-1:0]      row_r, row_nxt;
  logic [POS_W-1:0]      last_col, last_row;
  logic                  step;

  assign step     = !key_empty && !res_full;
  assign key_pop  = step;
  assign res_push = step;
  assign last_col = (cols_r == '0) ? '0 : POS_W'(cols_r - 1'b1);
  assign last_row = (rows_r == '0) ? '0 : POS_W'(rows_r - 1'b1);

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_SCREEN_ROWS: rows_nxt = cfg_wdata;
        REG_SCREEN_COLS: cols_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step && key_word.key_valid) begin
      unique case (key_word.key_code)
        KEY_LEFT:  if (col_r != '0)      col_nxt = col_r - 1'b1;
        KEY_RIGHT: if (col_r < last_col) col_nxt = col_r + 1'b1;
        KEY_UP:    if (row_r != '0)      row_nxt = row_r - 1'b1;
        KEY_DOWN:  if (row_r < last_row) row_nxt = row_r + 1'b1;
        KEY_PGUP:  row_nxt = '0;
        KEY_PGDN:  row_nxt = last_row;
        KEY_HOME:  col_nxt = '0;
        KEY_END:   col_nxt = last_col;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_word            = '0;
    res_word.key_valid  = key_word.key_valid;
    res_word.key_code   = key_word.key_valid ? key_word.key_code : '0;
    res_word.cursor_col = col_nxt;
    res_word.cursor_row = row_nxt;
    res_word.quit       = key_word.key_valid && (key_word.key_code == KEY_QUIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SCREEN_ROWS_RST;
      cols_r <= SCREEN_COLS_RST;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape key decoder and its clamped cursor.
// Terminal bytes and read timeouts go in through the push/full queue port.
// Decoded words are popped from the empty/pop side and compared field by
// field against an in-bench decoder and cursor model.
// A short directed table comes first. Random traffic follows: mostly
// well-formed escape sequences, plus raw bytes, timeouts and broken
// sequences. It runs over several screen sizes and handshake idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import ekd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_PHASES    = 10;
  localparam int PHASE_WORDS = 150;
  localparam int HOLD_LEN    = 200;
  localparam int N_DIR       = 33;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LB     = 8'h5B;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CTRL_Q = 8'h11;

  // -1 picks a random size
  localparam int PH_ROWS [N_PHASES] = '{24, 1023, 4, 0, 1, -1, 1023, 1, -1, 24};
  localparam int PH_COLS [N_PHASES] = '{80, 1023, 6, 0, 1, -1, 1, 1023, -1, 80};

  localparam logic [7:0] CSI_FINALS [6] = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h46};

  typedef struct packed {
    logic      fixed;
    in_word_t  word;
    out_word_t want;
  } dir_row_t;

  localparam in_word_t  W_TMO  = {1'b1, 8'h00};
  localparam out_word_t NO_KEY = '0;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{1'b1, W_TMO,              NO_KEY},
    '{1'b1, {1'b0, 8'h00},      {1'b1, 9'd0, 10'd0, 10'd0, 1'b0}},
    '{1'b1, {1'b0, 8'hFF},      {1'b1, 9'd255, 10'd0, 10'd0, 1'b0}},
    '{1'b1, {1'b0, CH_CTRL_Q},  {1'b1, KEY_QUIT, 10'd0, 10'd0, 1'b1}},
    '{1'b1, {1'b0, CH_ESC},     NO_KEY},
    '{1'b1, {1'b0, CH_LB},      NO_KEY},
    '{1'b1, {1'b0, 8'h36},      NO_KEY},
    '{1'b1, {1'b0, CH_TILDE},   {1'b1, KEY_PGDN, 10'd0, 10'd23, 1'b0}},
    '{1'b1, {1'b0, CH_ESC},     {1'b0, 9'd0, 10'd0, 10'd23, 1'b0}},
    '{1'b1, {1'b0, CH_LB},      {1'b0, 9'd0, 10'd0, 10'd23, 1'b0}},
    '{1'b1, {1'b0, 8'h46},      {1'b1, KEY_END, 10'd79, 10'd23, 1'b0}},
    // right and down while already at the edge, then home, page up and delete
    '{1'b0, {1'b0, CH_ESC},     NO_KEY},
    '{1'b0, {1'b0, CH_LB},      NO_KEY},
    '{1'b0, {1'b0, 8'h43},      NO_KEY},
    '{1'b0, {1'b0, CH_ESC},     NO_KEY},
    '{1'b0, {1'b0, CH_LB},      NO_KEY},
    '{1'b0, {1'b0, 8'h42},      NO_KEY},
    '{1'b0, {1'b0, CH_ESC},     NO_KEY},
    '{1'b0, {1'b0, CH_O},       NO_KEY},
    '{1'b0, {1'b0, 8'h48},      NO_KEY},
    '{1'b0, {1'b0, CH_ESC},     NO_KEY},
    '{1'b0, {1'b0, CH_LB},      NO_KEY},
    '{1'b0, {1'b0, 8'h35},      NO_KEY},
    '{1'b0, {1'b0, CH_TILDE},   NO_KEY},
    '{1'b0, {1'b0, CH_ESC},     NO_KEY},
    '{1'b0, {1'b0, CH_LB},      NO_KEY},
    '{1'b0, {1'b0, 8'h33},      NO_KEY},
    '{1'b0, {1'b0, CH_TILDE},   NO_KEY},
    // timeout inside a sequence
    '{1'b1, {1'b0, CH_ESC},     NO_KEY},
    '{1'b0, W_TMO,              NO_KEY},
    // ESC as the follow byte, then an unknown final
    '{1'b0, {1'b0, CH_ESC},     NO_KEY},
    '{1'b0, {1'b0, CH_ESC},     NO_KEY},
    '{1'b0, {1'b0, 8'h41},      NO_KEY}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  in_word_t              in_word   = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = REG_SCREEN_ROWS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  escape_key_decoder_cursor_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // decoder and cursor model state
  phase_t          pred_phase = PH_IDLE;
  logic [7:0]      pred_lead  = '0;
  logic [7:0]      pred_digit = '0;
  logic [POS_W-1:0] pred_col  = '0;
  logic [POS_W-1:0] pred_row  = '0;
  logic [CFG_DATA_W-1:0] pred_rows = SCREEN_ROWS_RST;
  logic [CFG_DATA_W-1:0] pred_cols = SCREEN_COLS_RST;

  out_word_t key_expect_q [$];
  in_word_t  burst_q [$];

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int fail_cnt      = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int cycle_cnt     = 0;
  logic hold_tog    = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_cnt    = 0;

  function automatic out_word_t decode_key_word(in_word_t w);
    out_word_t        r;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic [POS_W-1:0] last_col;
    logic [POS_W-1:0] last_row;
    hit      = 1'b0;
    key      = '0;
    last_col = (pred_cols == 0) ? '0 : pred_cols - 1'b1;
    last_row = (pred_rows == 0) ? '0 : pred_rows - 1'b1;
    if (w.cmd) begin
      hit        = (pred_phase != PH_IDLE);
      key        = KEY_ESC;
      pred_phase = PH_IDLE;
    end else begin
      case (pred_phase)
        PH_IDLE: begin
          if (w.in_byte == CH_ESC) begin
            pred_phase = PH_ESC;
          end else begin
            hit = 1'b1;
            key = {1'b0, w.in_byte};
          end
        end
        PH_ESC: begin
          pred_lead  = w.in_byte;
          pred_phase = PH_FOLLOW;
        end
        PH_FOLLOW: begin
          if (pred_lead == CH_LB && w.in_byte >= 8'h30 && w.in_byte <= 8'h39) begin
            pred_digit = w.in_byte;
            pred_phase = PH_DIGIT;
          end else begin
            hit = 1'b1;
            key = KEY_ESC;
            if (pred_lead == CH_LB) begin
              case (w.in_byte)
                8'h41:   key = KEY_UP;
                8'h42:   key = KEY_DOWN;
                8'h43:   key = KEY_RIGHT;
                8'h44:   key = KEY_LEFT;
                8'h48:   key = KEY_HOME;
                8'h46:   key = KEY_END;
                default: key = KEY_ESC;
              endcase
            end else if (pred_lead == CH_O) begin
              if (w.in_byte == 8'h48) key = KEY_HOME;
              if (w.in_byte == 8'h46) key = KEY_END;
            end
            pred_phase = PH_IDLE;
          end
        end
        default: begin
          hit = 1'b1;
          key = KEY_ESC;
          if (w.in_byte == CH_TILDE) begin
            case (pred_digit)
              8'h31, 8'h37: key = KEY_HOME;
              8'h33:        key = KEY_DEL;
              8'h34, 8'h38: key = KEY_END;
              8'h35:        key = KEY_PGUP;
              8'h36:        key = KEY_PGDN;
              default:      key = KEY_ESC;
            endcase
          end
          pred_phase = PH_IDLE;
        end
      endcase
    end
    if (hit) begin
      case (key)
        KEY_LEFT:  if (pred_col != 0) pred_col = pred_col - 1'b1;
        KEY_RIGHT: if (pred_col < last_col) pred_col = pred_col + 1'b1;
        KEY_UP:    if (pred_row != 0) pred_row = pred_row - 1'b1;
        KEY_DOWN:  if (pred_row < last_row) pred_row = pred_row + 1'b1;
        KEY_PGUP:  pred_row = '0;
        KEY_PGDN:  pred_row = last_row;
        KEY_HOME:  pred_col = '0;
        KEY_END:   pred_col = last_col;
        default: ;
      endcase
    end
    r.key_valid  = hit;
    r.key_code   = hit ? key : '0;
    r.cursor_col = pred_col;
    r.cursor_row = pred_row;
    r.quit       = hit && (key == KEY_QUIT);
    return r;
  endfunction

  function automatic in_word_t byte_word(logic [7:0] b);
    return {1'b0, b};
  endfunction

  function automatic in_word_t timeout_word();
    return {1'b1, 8'($urandom_range(255))};
  endfunction

  function automatic logic [7:0] digit_byte();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // one key's worth of traffic, mostly well-formed sequences
  function automatic void add_burst();
    int pick;
    pick = $urandom_range(99);
    if (pick < 18) begin
      burst_q.push_back(byte_word(8'($urandom_range(255))));
    end else if (pick < 26) begin
      burst_q.push_back(timeout_word());
    end else if (pick < 30) begin
      burst_q.push_back(byte_word(CH_CTRL_Q));
    end else if (pick < 52) begin
      burst_q.push_back(byte_word(CH_ESC));
      burst_q.push_back(byte_word(CH_LB));
      burst_q.push_back(byte_word(CSI_FINALS[$urandom_range(5)]));
    end else if (pick < 72) begin
      burst_q.push_back(byte_word(CH_ESC));
      burst_q.push_back(byte_word(CH_LB));
      burst_q.push_back(byte_word(digit_byte()));
      burst_q.push_back(byte_word(CH_TILDE));
    end else if (pick < 80) begin
      burst_q.push_back(byte_word(CH_ESC));
      burst_q.push_back(byte_word(CH_O));
      burst_q.push_back(byte_word($urandom_range(1) ? 8'h48 : 8'h46));
    end else begin
      burst_q.push_back(byte_word(CH_ESC));
      case ($urandom_range(4))
        0: begin
          burst_q.push_back(byte_word(8'($urandom_range(255))));
          burst_q.push_back(byte_word(8'($urandom_range(255))));
        end
        1: begin
          burst_q.push_back(byte_word(CH_LB));
          burst_q.push_back(byte_word(digit_byte()));
          burst_q.push_back(byte_word(8'($urandom_range(255))));
        end
        2: burst_q.push_back(timeout_word());
        3: begin
          burst_q.push_back(byte_word(CH_LB));
          if ($urandom_range(1)) burst_q.push_back(byte_word(digit_byte()));
          burst_q.push_back(timeout_word());
        end
        default: begin
          burst_q.push_back(byte_word(CH_ESC));
          burst_q.push_back(byte_word(8'($urandom_range(255))));
        end
      endcase
    end
  endfunction

  task automatic send_word(input in_word_t w, input logic fixed, input out_word_t want);
    out_word_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    pred = decode_key_word(w);
    key_expect_q.push_back(fixed ? want : pred);
    words_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (key_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_screen(input logic [CFG_DATA_W-1:0] rows,
                            input logic [CFG_DATA_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SCREEN_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_idx   <= REG_SCREEN_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pred_rows = rows;
    pred_cols = cols;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  task automatic check_key_word(input out_word_t got);
    out_word_t exp_w;
    if (key_expect_q.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      fail_cnt++;
    end else begin
      exp_w = key_expect_q.pop_front();
      check_field("key_valid", exp_w.key_valid, got.key_valid);
      check_field("key_code", exp_w.key_code, got.key_code);
      check_field("cursor_col", exp_w.cursor_col, got.cursor_col);
      check_field("cursor_row", exp_w.cursor_row, got.cursor_row);
      check_field("quit", exp_w.quit, got.quit);
      words_checked++;
    end
  endtask

  // result side: check, then pick next pop
  always @(posedge clk) begin
    if (rst_n && pop && !empty) check_key_word(out_word);
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_cnt  = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int ph;
    int phase_sent;
    logic paused;
    logic [CFG_DATA_W-1:0] rows;
    logic [CFG_DATA_W-1:0] cols;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        wait_drained();
        rows = (PH_ROWS[ph] < 0) ? CFG_DATA_W'($urandom_range(1023)) : CFG_DATA_W'(PH_ROWS[ph]);
        cols = (PH_COLS[ph] < 0) ? CFG_DATA_W'($urandom_range(1023)) : CFG_DATA_W'(PH_COLS[ph]);
        set_screen(rows, cols);
      end
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 73; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 73; end
        default: begin snd_idle_pct = 30; rcv_stall_pct = 30; end
      endcase
      if (ph == 0) begin
        for (int i = 0; i < N_DIR; i++) send_word(DIR_TAB[i].word, DIR_TAB[i].fixed,
                                                 DIR_TAB[i].want);
        // long receiver hold so the queues fill and full rises
        hold_tog = ~hold_tog;
      end
      phase_sent = 0;
      paused     = 1'b0;
      while (phase_sent < PHASE_WORDS) begin
        if (ph == 2 && !paused && phase_sent >= PHASE_WORDS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        add_burst();
        while (burst_q.size() != 0) begin
          send_word(burst_q.pop_front(), 1'b0, NO_KEY);
          phase_sent++;
        end
      end
    end
    wait_drained();
    repeat (8) @(posedge clk);
    $display("tb_top: %0d words in, %0d results checked", words_sent, words_checked);
    $display("tb_top: %0d screen sizes incl. zero, minimum, maximum and shrunk",
             N_PHASES);
    if (fail_cnt == 0 && key_expect_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
